// ----- design/smfr_pkg.sv -----
// shared types, constants and helpers for the sign-magnitude frame receiver
`timescale 1ns / 1ps
`default_nettype none

package smfr_pkg;

    // default frame capacity in signed values
    localparam int MAX_VALUES_DEF = 16;

    // depth of the result queue, a power of two
    localparam int OQ_DEPTH = 4;

    // configuration port
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;
    localparam logic REG_VALUE_COUNT = 1'b0;
    localparam logic [4:0] VALUE_COUNT_RST = 5'd4;

    // framing constants
    localparam logic [7:0] HEADER_BYTE = 8'hFF;
    localparam logic [7:0] TERM_BYTE   = 8'h00;

    typedef enum logic [2:0] {
        STAT_PROGRESS    = 3'd0,
        STAT_VALUE       = 3'd1,
        STAT_BAD_TERM    = 3'd2,
        STAT_HDR_TIMEOUT = 3'd3,
        STAT_PAY_TIMEOUT = 3'd4,
        STAT_STRAY       = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        S_HUNT,
        S_COLLECT,
        S_DUMP
    } state_t;

    typedef struct packed {
        logic       mode;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed {
        status_t            status;
        logic [4:0]         index;
        logic signed [15:0] value;
        logic               last;
    } result_t;

    // sign-magnitude pair to two's complement, negative zero gives zero
    function automatic logic signed [15:0] sm_decode(input logic [7:0] hi,
                                                     input logic [7:0] lo);
        logic [15:0] mag;
        mag = {1'b0, hi[6:0], lo};
        return hi[7] ? $signed(16'(-mag)) : $signed(mag);
    endfunction

    // status-only result
    function automatic result_t status_result(input status_t st);
        result_t r;
        r.status = st;
        r.index  = '0;
        r.value  = '0;
        r.last   = 1'b1;
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- design/smfr_ram.sv -----
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module smfr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 17
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- design/smfr_outq.sv -----
// small result queue between the parser and the result channel
`timescale 1ns / 1ps
`default_nettype none

module smfr_outq #(
    parameter int DEPTH = smfr_pkg::OQ_DEPTH
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       push,
    input  wire smfr_pkg::result_t          push_data,
    output logic      [$clog2(DEPTH+1)-1:0] count,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output smfr_pkg::result_t               m_data
);
    import smfr_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    result_t         fifo_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            pop;

    assign pop     = m_valid && m_ready;
    assign m_valid = (count_reg != '0);
    assign m_data  = fifo_reg[rd_ptr_reg];
    assign count   = count_reg;

    always_comb begin
        wr_ptr_next = push ? PW'(wr_ptr_reg + PW'(1)) : wr_ptr_reg;
        rd_ptr_next = pop ? PW'(rd_ptr_reg + PW'(1)) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = CW'(count_reg + CW'(1));
        end else if (pop && !push) begin
            count_next = CW'(count_reg - CW'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // push only with a free slot, the parser checks occupancy first
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (count_reg < CW'(DEPTH)))
        else $error("result queue overflow");

    // occupancy moves by one at most per cycle
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (count_reg == CW'($past(count_reg) + CW'(1))))
        else $error("result queue count did not follow a push");

    a_wr_ptr_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with split pointers");

endmodule

`default_nettype wire

// ----- design/smfr_parser.sv -----
// frame parser: header hunt, payload capture into value memory, readout sequencer
`timescale 1ns / 1ps
`default_nettype none

module smfr_parser #(
    parameter int MAX_VALUES = smfr_pkg::MAX_VALUES_DEF,
    parameter int QDEPTH     = smfr_pkg::OQ_DEPTH
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic [4:0]                          value_count,
    // input channel
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire smfr_pkg::item_t                     s_data,
    // value memory
    output logic                                     mem_we,
    output logic      [$clog2(MAX_VALUES+1)-1:0]     mem_waddr,
    output logic      [15:0]                         mem_wdata,
    output logic      [$clog2(MAX_VALUES+1)-1:0]     mem_raddr,
    input  wire logic [15:0]                         mem_rdata,
    // result queue
    output logic                                     push,
    output smfr_pkg::result_t                        push_data,
    input  wire logic [$clog2(QDEPTH+1)-1:0]         q_count
);
    import smfr_pkg::*;

    localparam int AW    = $clog2(MAX_VALUES + 1);
    localparam int POS_W = AW + 1;

    state_t           state_reg, state_next;
    logic             hdr_seen_reg, hdr_seen_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       hold_reg, hold_next;
    logic [AW-1:0]    n_reg, n_next;
    logic [AW-1:0]    rd_k_reg, rd_k_next;
    logic             pend_reg, pend_next;
    logic [AW-1:0]    pend_k_reg, pend_k_next;
    logic             pend_last_reg, pend_last_next;

    logic [AW-1:0]    n_act;
    logic [POS_W-1:0] term_pos;
    logic             accept;
    logic             room;

    // active value count, clamped to the frame capacity
    always_comb begin
        if (int'(value_count) > MAX_VALUES) begin
            n_act = AW'(MAX_VALUES);
        end else begin
            n_act = AW'(value_count);
        end
    end

    assign term_pos = {n_act, 1'b1};
    assign s_ready  = (state_reg != S_DUMP) && !pend_reg && (int'(q_count) < QDEPTH);
    assign accept   = s_valid && s_ready;
    assign room     = (int'(q_count) + int'(pend_reg)) < QDEPTH;

    assign mem_waddr = pos_reg[POS_W-1:1];
    assign mem_raddr = rd_k_reg;

    always_comb begin
        state_next     = state_reg;
        hdr_seen_next  = hdr_seen_reg;
        pos_next       = pos_reg;
        hold_next      = hold_reg;
        n_next         = n_reg;
        rd_k_next      = rd_k_reg;
        pend_next      = 1'b0;
        pend_k_next    = pend_k_reg;
        pend_last_next = pend_last_reg;
        mem_we         = 1'b0;
        mem_wdata      = 16'(sm_decode(hold_reg, s_data.rx_byte));
        push           = 1'b0;
        push_data      = status_result(STAT_PROGRESS);

        unique case (state_reg)
            S_HUNT: begin
                if (accept) begin
                    push = 1'b1;
                    if (s_data.mode) begin
                        push_data     = status_result(STAT_HDR_TIMEOUT);
                        hdr_seen_next = 1'b0;
                    end else if (s_data.rx_byte == HEADER_BYTE) begin
                        push_data = status_result(STAT_PROGRESS);
                        if (hdr_seen_reg) begin
                            state_next    = S_COLLECT;
                            hdr_seen_next = 1'b0;
                            pos_next      = '0;
                        end else begin
                            hdr_seen_next = 1'b1;
                        end
                    end else begin
                        push_data     = status_result(STAT_STRAY);
                        hdr_seen_next = 1'b0;
                    end
                end
            end
            S_COLLECT: begin
                if (accept) begin
                    if (s_data.mode) begin
                        push       = 1'b1;
                        push_data  = status_result(STAT_PAY_TIMEOUT);
                        state_next = S_HUNT;
                        pos_next   = '0;
                    end else if (pos_reg >= term_pos) begin
                        pos_next = '0;
                        if (s_data.rx_byte != TERM_BYTE) begin
                            push       = 1'b1;
                            push_data  = status_result(STAT_BAD_TERM);
                            state_next = S_HUNT;
                        end else begin
                            state_next = S_DUMP;
                            n_next     = n_act;
                            rd_k_next  = '0;
                        end
                    end else begin
                        push      = 1'b1;
                        push_data = status_result(STAT_PROGRESS);
                        pos_next  = POS_W'(pos_reg + POS_W'(1));
                        if (pos_reg == '0) begin
                            mem_we    = 1'b1;
                            mem_wdata = {8'h00, s_data.rx_byte};
                        end else if (pos_reg[0]) begin
                            hold_next = s_data.rx_byte;
                        end else begin
                            mem_we = 1'b1;
                        end
                    end
                end
            end
            S_DUMP: begin
                if (room) begin
                    pend_next      = 1'b1;
                    pend_k_next    = rd_k_reg;
                    pend_last_next = (rd_k_reg == n_reg);
                    if (rd_k_reg == n_reg) begin
                        state_next = S_HUNT;
                    end else begin
                        rd_k_next = AW'(rd_k_reg + AW'(1));
                    end
                end
            end
            default: begin
                state_next = S_HUNT;
            end
        endcase

        // read data lands in the cycle after the read, never alongside an accept
        if (pend_reg) begin
            push             = 1'b1;
            push_data.status = STAT_VALUE;
            push_data.index  = 5'(pend_k_reg);
            push_data.value  = $signed(mem_rdata);
            push_data.last   = pend_last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_HUNT;
            hdr_seen_reg <= 1'b0;
            pos_reg      <= '0;
            hold_reg     <= '0;
            pend_reg     <= 1'b0;
        end else begin
            state_reg    <= state_next;
            hdr_seen_reg <= hdr_seen_next;
            pos_reg      <= pos_next;
            hold_reg     <= hold_next;
            pend_reg     <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg         <= n_next;
        rd_k_reg      <= rd_k_next;
        pend_k_reg    <= pend_k_next;
        pend_last_reg <= pend_last_next;
    end

    // a pending read only follows a readout cycle
    a_pend_from_dump: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> ($past(state_reg) == S_DUMP))
        else $error("memory read outside readout");

    // readout never runs past the frame length
    a_dump_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DUMP) |-> (rd_k_reg <= n_reg))
        else $error("readout index beyond frame length");

    // the marked value is the last position of the frame
    a_last_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (pend_reg && pend_last_reg) |-> (pend_k_reg == n_reg))
        else $error("last flag on wrong value");

    // no memory write while reading out
    a_no_write_in_dump: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DUMP || pend_reg) |-> !mem_we)
        else $error("value memory written during readout");

endmodule

`default_nettype wire

// ----- design/sign_magnitude_frame_receiver.sv -----
// top level of the sign-magnitude frame receiver
`timescale 1ns / 1ps
`default_nettype none

// Receives serial bytes and receive-timeout events as s_ transactions and
// produces status and value transactions on m_. The parser hunts for two
// 0xFF header bytes, then takes a raw byte, value_count high/low byte pairs
// in sign-magnitude form and a terminator byte. Every byte or timeout yields
// one status-only transaction (last set), except a zero terminator, which
// yields value_count+1 value transactions: the raw byte at index 0, then the
// decoded signed values, the final one with last set. Decoded values live in
// a single value memory of MAX_VALUES+1 entries with a registered read; it
// needs no clearing after reset. value_count above MAX_VALUES is taken as
// MAX_VALUES. Bytes and timeouts are accepted back to back as long as the
// four-entry result queue has room and no readout is running. A zero
// terminator starts a readout that reads one memory entry per cycle while
// the queue has space; the input is held off until the last memory read has
// returned its data. The user must write value_count through the APB port
// at byte address 0 only while the block is idle; the block does not
// enforce this.

module sign_magnitude_frame_receiver #(
    parameter int MAX_VALUES = smfr_pkg::MAX_VALUES_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // input transactions
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire smfr_pkg::item_t                 s_data,
    // result transactions
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output smfr_pkg::result_t                    m_data,
    // configuration port
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [smfr_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [smfr_pkg::CFG_DATA_W-1:0] pwdata,
    output logic      [smfr_pkg::CFG_DATA_W-1:0] prdata,
    output logic                                 pready
);
    import smfr_pkg::*;

    localparam int AW = $clog2(MAX_VALUES + 1);
    localparam int CW = $clog2(OQ_DEPTH + 1);

    // configuration register
    logic [4:0] value_count_reg;
    logic       reg_sel;
    logic       cfg_wr;

    // value memory interface
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [15:0]   mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [15:0]   mem_rdata;

    // parser to result queue
    logic          push;
    result_t       push_data;
    logic [CW-1:0] q_count;

    // apb: zero wait states, word-addressed register file of one entry
    assign pready  = 1'b1;
    assign reg_sel = (paddr[CFG_ADDR_W-1:2] == REG_VALUE_COUNT);
    assign cfg_wr  = psel && penable && pwrite && pready && reg_sel;
    assign prdata  = reg_sel ? CFG_DATA_W'(value_count_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            value_count_reg <= VALUE_COUNT_RST;
        end else if (cfg_wr) begin
            value_count_reg <= pwdata[4:0];
        end
    end

    // header hunt, payload capture and readout sequencing
    smfr_parser #(
        .MAX_VALUES (MAX_VALUES),
        .QDEPTH     (OQ_DEPTH)
    ) u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .value_count (value_count_reg),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_raddr   (mem_raddr),
        .mem_rdata   (mem_rdata),
        .push        (push),
        .push_data   (push_data),
        .q_count     (q_count)
    );

    // raw byte and decoded values, one entry per frame position
    smfr_ram #(
        .WIDTH (16),
        .DEPTH (MAX_VALUES + 1)
    ) u_value_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // result queue decouples the parser from m_ready stalls
    smfr_outq #(
        .DEPTH (OQ_DEPTH)
    ) u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .count     (q_count),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // input held off while the queue is full
    a_full_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_count == CW'(OQ_DEPTH)) |-> !s_ready)
        else $error("input accepted with full result queue");

    // register write lands at the next edge
    a_cfg_write: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr |=> (value_count_reg == $past(pwdata[4:0])))
        else $error("value_count write lost");

    // value transactions come only from memory readout
    a_value_source: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && push_data.status == STAT_VALUE) |-> !(s_valid && s_ready))
        else $error("value result pushed alongside an input transaction");

endmodule

`default_nettype wire
